### design/distance_constraint_solver_unit_assert.svh
// assertion macros for the distance constraint solver
`ifndef DISTANCE_CONSTRAINT_SOLVER_UNIT_ASSERT_SVH
`define DISTANCE_CONSTRAINT_SOLVER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DCS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcs check failed");
`define DCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcs check failed");
`else
`define DCS_ASSERT_IMP(label, clk, rst, ante, cons)
`define DCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/dcs_pkg.sv
// shared types and constants of the distance constraint solver
package dcs_pkg;
   localparam int FRAC_BITS = 16;
   localparam int STIFF_BITS = 16;
   localparam int SHARE_BITS = 24;
   localparam int MIN_DIST = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int REQ_W = 256;
   localparam int RSP_W = 248;
   localparam int DIV_DIR_STEPS = FRAC_BITS + 1;
   localparam int DIV_SHARE_STEPS = SHARE_BITS + 1;
   localparam logic [16:0] STIFF_ONE = 17'd65536;

   typedef enum logic [1:0] {
      CSR_TARGET,
      CSR_STIFF,
      CSR_ENABLE
   } csr_index_type;

   typedef struct packed {
      logic [30:0] target;
      logic [16:0] stiff;
      logic        enable;
   } cfg_type;

   typedef struct packed {
      logic               en;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic [31:0]        ma;
      logic [31:0]        mb;
   } item_type;
endpackage

### design/dcs_fifo.sv
// short item queue between the front and the back
module dcs_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  dcs_pkg::item_type wr_item,
   input  logic              push,
   output logic              full,
   input  logic              pop,
   output dcs_pkg::item_type rd_item,
   output logic              rd_valid
);
   import dcs_pkg::*;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wptr_ff, rptr_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wr_item;
      end
   end
endmodule

### design/dcs_div.sv
// shared restoring divider, one quotient bit per cycle
module dcs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] numer,
   input  logic [33:0] denom,
   input  logic [4:0]  steps,
   output logic        done,
   output logic [24:0] quot
);
   logic [33:0] rem_ff, den_ff;
   logic [34:0] rem_try;
   logic        ge;
   logic        bit_ff, busy_ff, done_ff;
   logic [4:0]  cnt_ff;
   logic [24:0] quot_ff;

   assign rem_try = {rem_ff, bit_ff};
   assign ge      = (rem_try >= {1'b0, den_ff});
   assign done    = done_ff;
   assign quot    = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= numer[33-1:1] == '0 ? '0 : 34'(numer >> 1);
         bit_ff  <= numer[0];
         den_ff  <= denom;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? 34'(rem_try - {1'b0, den_ff}) : rem_try[33:0];
         bit_ff  <= 1'b0;
         quot_ff <= {quot_ff[23:0], ge};
      end
   end
endmodule

### design/dcs_front.sv
// front: accepts items, forms the separation and tags disabled items
module dcs_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [dcs_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       enable,
   output logic                       push,
   input  logic                       full,
   output dcs_pkg::item_type          item
);
   import dcs_pkg::*;

   function automatic logic signed [32:0] sub33(input logic [31:0] b, input logic [31:0] a);
      sub33 = $signed({b[31], b}) - $signed({a[31], a});
   endfunction

   assign req_tready = !full;
   assign push       = req_tvalid;

   always_comb begin
      item.en = enable;
      item.dx = sub33(req_tdata[127:96], req_tdata[31:0]);
      item.dy = sub33(req_tdata[159:128], req_tdata[63:32]);
      item.dz = sub33(req_tdata[191:160], req_tdata[95:64]);
      item.ma = req_tdata[223:192];
      item.mb = req_tdata[255:224];
   end
endmodule

### design/dcs_back.sv
// back: squares, square root, divisions and impulse products in sequence
module dcs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  dcs_pkg::item_type         item,
   input  logic                      item_valid,
   output logic                      item_pop,
   input  dcs_pkg::cfg_type          cfg,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [dcs_pkg::RSP_W-1:0] rsp_tdata
);
   import dcs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_CHECK, S_SA_WAIT, S_SB_WAIT,
      S_DIR_START, S_DIR_WAIT, S_M1, S_M2, S_M3, S_M4, S_M5, S_DONE
   } state_type;

   state_type          state_ff;
   logic signed [32:0] d_ff [3];
   logic [31:0]        ma_ff, mb_ff;
   logic [65:0]        acc_ff, acc_in;
   logic [69:0]        rad_ff;
   logic [34:0]        root_ff;
   logic [37:0]        srem_ff, sq_try, sq_trial;
   logic [5:0]         cnt_ff;
   logic signed [34:0] err_ff;
   logic [24:0]        sa_ff, sb_ff;
   logic [16:0]        q_ff;
   logic [34:0]        c2_ff;
   logic [67:0]        prod_ff;
   logic [34:0]        mul_a;
   logic [32:0]        mul_b;
   logic [1:0]         axis_ff;
   logic               app_a_ff, app_b_ff;
   logic signed [34:0] imp_a_ff [3], imp_b_ff [3];
   logic               div_start_ff, div_done;
   logic [32:0]        div_num_ff;
   logic [33:0]        div_den_ff;
   logic [4:0]         div_steps_ff;
   logic [24:0]        div_quot;
   logic signed [32:0] cur_d;
   logic [32:0]        cur_mag;
   logic [34:0]        err_mag, c_mag;
   logic [32:0]        tot;
   logic [16:0]        st;
   logic               neg_c;

   dcs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .numer (div_num_ff),
      .denom (div_den_ff),
      .steps (div_steps_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign cur_d    = d_ff[axis_ff];
   assign cur_mag  = cur_d[32] ? 33'(-cur_d) : 33'(cur_d);
   assign err_mag  = err_ff[34] ? 35'(-err_ff) : 35'(err_ff);
   assign tot      = {1'b0, ma_ff} + {1'b0, mb_ff};
   assign st       = (cfg.stiff > STIFF_ONE) ? STIFF_ONE : cfg.stiff;
   assign neg_c    = cur_d[32] ^ err_ff[34];
   assign acc_in   = acc_ff + 66'(prod_ff[64:0]);
   assign sq_try   = {srem_ff[35:0], rad_ff[69:68]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign c_mag    = prod_ff[SHARE_BITS+34:SHARE_BITS];
   assign item_pop = (state_ff == S_IDLE) && item_valid;
   assign rsp_tvalid = (state_ff == S_DONE);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQ_MUL: begin
            mul_a = 35'(cur_mag);
            mul_b = cur_mag;
         end
         S_M1: begin
            mul_a = err_mag;
            mul_b = 33'(q_ff);
         end
         S_M2: begin
            mul_a = prod_ff[FRAC_BITS+34:FRAC_BITS];
            mul_b = 33'(st);
         end
         S_M3: begin
            mul_a = prod_ff[STIFF_BITS+34:STIFF_BITS];
            mul_b = 33'(sa_ff);
         end
         S_M4: begin
            mul_a = c2_ff;
            mul_b = 33'(sb_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < 3; i++) begin
         rsp_tdata[35*i +: 35]       = imp_a_ff[i];
         rsp_tdata[35*(i+3) +: 35]   = imp_b_ff[i];
      end
      rsp_tdata[210]     = app_a_ff;
      rsp_tdata[211]     = app_b_ff;
      rsp_tdata[246:212] = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         err_ff       <= '0;
         div_start_ff <= 1'b0;
         axis_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         div_start_ff <= 1'b0;
         prod_ff      <= mul_a * mul_b;
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  d_ff[0]  <= item.dx;
                  d_ff[1]  <= item.dy;
                  d_ff[2]  <= item.dz;
                  ma_ff    <= item.ma;
                  mb_ff    <= item.mb;
                  acc_ff   <= '0;
                  axis_ff  <= '0;
                  app_a_ff <= 1'b0;
                  app_b_ff <= 1'b0;
                  for (int i = 0; i < 3; i++) begin
                     imp_a_ff[i] <= '0;
                     imp_b_ff[i] <= '0;
                  end
                  state_ff <= item.en ? S_SQ_MUL : S_DONE;
               end
            end
            S_SQ_MUL: state_ff <= S_SQ_ACC;
            S_SQ_ACC: begin
               acc_ff <= acc_in;
               if (axis_ff == 2'd2) begin
                  axis_ff  <= '0;
                  rad_ff   <= {4'b0, acc_in};
                  root_ff  <= '0;
                  srem_ff  <= '0;
                  cnt_ff   <= 6'd34;
                  state_ff <= S_SQRT;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_SQ_MUL;
               end
            end
            S_SQRT: begin
               rad_ff <= {rad_ff[67:0], 2'b00};
               if (sq_try >= sq_trial) begin
                  srem_ff <= sq_try - sq_trial;
                  root_ff <= {root_ff[33:0], 1'b1};
               end else begin
                  srem_ff <= sq_try;
                  root_ff <= {root_ff[33:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               err_ff <= $signed(root_ff) - $signed({4'b0, cfg.target});
               if (root_ff >= 35'(MIN_DIST) && tot != '0) begin
                  app_a_ff     <= (ma_ff != '0);
                  app_b_ff     <= (mb_ff != '0);
                  div_start_ff <= 1'b1;
                  div_num_ff   <= {1'b0, mb_ff};
                  div_den_ff   <= {1'b0, tot};
                  div_steps_ff <= 5'(DIV_SHARE_STEPS);
                  state_ff     <= S_SA_WAIT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SA_WAIT: begin
               if (div_done) begin
                  sa_ff        <= div_quot;
                  div_start_ff <= 1'b1;
                  div_num_ff   <= {1'b0, ma_ff};
                  state_ff     <= S_SB_WAIT;
               end
            end
            S_SB_WAIT: begin
               if (div_done) begin
                  sb_ff    <= div_quot;
                  state_ff <= S_DIR_START;
               end
            end
            S_DIR_START: begin
               div_start_ff <= 1'b1;
               div_num_ff   <= cur_mag;
               div_den_ff   <= root_ff[33:0];
               div_steps_ff <= 5'(DIV_DIR_STEPS);
               state_ff     <= S_DIR_WAIT;
            end
            S_DIR_WAIT: begin
               if (div_done) begin
                  q_ff     <= div_quot[16:0];
                  state_ff <= S_M1;
               end
            end
            S_M1: state_ff <= S_M2;
            S_M2: state_ff <= S_M3;
            S_M3: begin
               c2_ff    <= prod_ff[STIFF_BITS+34:STIFF_BITS];
               state_ff <= S_M4;
            end
            S_M4: begin
               if (app_a_ff) begin
                  imp_a_ff[axis_ff] <= neg_c ? -$signed(c_mag) : $signed(c_mag);
               end
               state_ff <= S_M5;
            end
            S_M5: begin
               if (app_b_ff) begin
                  imp_b_ff[axis_ff] <= neg_c ? $signed(c_mag) : -$signed(c_mag);
               end
               if (axis_ff == 2'd2) begin
                  state_ff <= S_DONE;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_DIR_START;
               end
            end
            S_DONE: begin
               if (rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### design/distance_constraint_solver_unit.sv
// top level of the distance constraint solver
// a solved item goes from acceptance to result through the squares of the three axes,
//   35 square root steps, two share divisions and three axis passes
// a disabled item skips all steps; near-coincident centers or no mass stop after the root
// throughput: one item per back-end pass, which ends only when its result is taken
// reset: synchronous, active high; registers return to target 1.0, stiffness 1.0, enabled
`include "distance_constraint_solver_unit_assert.svh"
module distance_constraint_solver_unit #(
   parameter int QUEUE_DEPTH = dcs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z, a_mass, b_mass
   input  logic [dcs_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // a_impulse_x/y/z, b_impulse_x/y/z, apply_a, apply_b, length_error, zero pad
   output logic [dcs_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import dcs_pkg::*;

   cfg_type        cfg_ff;
   logic           q_push, q_full;
   item_type       front_item, back_item;
   logic           back_valid, back_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target <= 31'd65536;
         cfg_ff.stiff  <= STIFF_ONE;
         cfg_ff.enable <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET: cfg_ff.target <= csr_data[30:0];
            CSR_STIFF:  cfg_ff.stiff  <= csr_data[16:0];
            CSR_ENABLE: cfg_ff.enable <= csr_data[0];
            default: ;
         endcase
      end
   end

   dcs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .enable     (cfg_ff.enable),
      .push       (q_push),
      .full       (q_full),
      .item       (front_item)
   );

   dcs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_item  (front_item),
      .push     (q_push),
      .full     (q_full),
      .pop      (back_pop),
      .rd_item  (back_item),
      .rd_valid (back_valid)
   );

   dcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_valid (back_valid),
      .item_pop   (back_pop),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `DCS_ASSERT_IMP(a_unapplied_zero, clock, reset, rsp_tvalid && !rsp_tdata[210], rsp_tdata[104:0] == '0)
   `DCS_ASSERT_IMP(b_unapplied_zero, clock, reset, rsp_tvalid && !rsp_tdata[211], rsp_tdata[209:105] == '0)
   `DCS_ASSERT_NEXT(rsp_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid)
endmodule
